// File: hw/rtl/tcce_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package tcce_pkg;

  localparam int CURSOR_W = 11;
  localparam int ADDR_W   = 11;

  localparam logic [7:0] CH_NEWLINE   = 8'h0A;
  localparam logic [7:0] CH_BACKSPACE = 8'h08;
  localparam logic [7:0] CH_SPACE     = 8'h20;

  typedef enum logic [2:0] {
    OP_PUT   = 3'd0,
    OP_SET   = 3'd1,
    OP_MOVE  = 3'd2,
    OP_CLEAR = 3'd3,
    OP_READ  = 3'd4
  } opcode_e;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_EXEC,
    ST_WALK_RD,
    ST_WALK_CHK,
    ST_DIV,
    ST_CLEAR,
    ST_EMIT
  } tcce_state_e;

  typedef struct packed {
    logic [2:0]         opcode;
    logic [7:0]         char_code;
    logic signed [15:0] cursor_value;
    logic [2:0]         background;
    logic [3:0]         foreground;
    logic               blink_on;
    logic [ADDR_W-1:0]  cell_address;
  } cmd_beat_t;

  typedef struct packed {
    logic [CURSOR_W-1:0] cursor_now;
    logic [7:0]          cell_char;
    logic [7:0]          cell_attr;
  } rsp_beat_t;

endpackage

`default_nettype wire

// File: hw/rtl/tcce_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface tcce_cmd_if import tcce_pkg::*; ();
  logic      valid;
  logic      ready;
  cmd_beat_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface tcce_rsp_if import tcce_pkg::*; ();
  logic      valid;
  logic      ready;
  rsp_beat_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/tcce_col_div.sv
`timescale 1ns / 1ps
`default_nettype none

module tcce_col_div import tcce_pkg::*; #(
  parameter int DIVIDEND_W  = 11,
  parameter int NUM_COLUMNS = 80
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start_i,
  input  logic [DIVIDEND_W-1:0]            dividend_i,
  output logic                             done_o,
  output logic [$clog2(NUM_COLUMNS)-1:0]   rem_o
);

  localparam int COL_W   = $clog2(NUM_COLUMNS);
  localparam int SHIFT   = DIVIDEND_W + COL_W;
  localparam int RECIP_W = DIVIDEND_W + 2;
  localparam int PROD_W  = DIVIDEND_W + RECIP_W;
  localparam int QUO_W   = PROD_W - SHIFT;

  localparam logic [RECIP_W-1:0] RECIP =
    RECIP_W'(((2 ** SHIFT) + NUM_COLUMNS - 1) / NUM_COLUMNS);

  logic                  stage1_q, stage2_q, done_q;
  logic [DIVIDEND_W-1:0] num_q;
  logic [QUO_W-1:0]      quo_q;
  logic [COL_W-1:0]      rem_q;
  logic [PROD_W-1:0]     prod;
  logic [DIVIDEND_W-1:0] back;

  // quotient by reciprocal multiply, then remainder by multiply-subtract
  assign prod = PROD_W'(num_q) * PROD_W'(RECIP);
  assign back = num_q - DIVIDEND_W'(quo_q) * DIVIDEND_W'(NUM_COLUMNS);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage1_q <= 1'b0;
      stage2_q <= 1'b0;
      done_q   <= 1'b0;
    end else begin
      stage1_q <= start_i;
      stage2_q <= stage1_q;
      done_q   <= stage2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= dividend_i;
    end
    if (stage1_q) begin
      quo_q <= prod[PROD_W-1:SHIFT];
    end
    if (stage2_q) begin
      rem_q <= back[COL_W-1:0];
    end
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;

endmodule

`default_nettype wire

// File: hw/rtl/text_console_cursor_engine_core.sv
`timescale 1ns / 1ps
`default_nettype none

// Text console with cursor. Characters and attributes live in two synchronous
// RAMs of NUM_COLUMNS*NUM_ROWS bytes, each with one write and one read port;
// every command beat returns one response beat. After reset the block sweeps
// both RAMs to space / zero, one cell per cycle, before cmd ready rises.
// Backspace from column 0 of a lower row walks back over blank cells, one RAM
// read and compare per cell, and stops behind a non-blank cell or at cell 0.
// For set and move the column is recovered by a reciprocal multiply and a
// multiply-subtract. Clear makes one RAM write per cell. A finished response
// waits in an output register; a response that finds that register full and
// not being read is held, and no command is taken until it is loaded.
module text_console_cursor_engine_core import tcce_pkg::*; #(
  parameter int NUM_COLUMNS = 80,
  parameter int NUM_ROWS    = 25
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  tcce_cmd_if.sink   cmd_i,
  tcce_rsp_if.source rsp_o
);

  localparam int CELLS          = NUM_COLUMNS * NUM_ROWS;
  localparam int LAST_CELL      = CELLS - 1;
  localparam int CELL_W         = $clog2(CELLS);
  localparam int COL_W          = $clog2(NUM_COLUMNS);
  localparam int LAST_ROW_START = (NUM_ROWS - 1) * NUM_COLUMNS;

  localparam logic [CELL_W-1:0] LAST_CELL_C = CELL_W'(LAST_CELL);
  localparam logic [CELL_W-1:0] LAST_ROW_C  = CELL_W'(LAST_ROW_START);
  localparam logic [CELL_W-1:0] COLS_C      = CELL_W'(NUM_COLUMNS);
  localparam logic [COL_W-1:0]  LAST_COL_C  = COL_W'(NUM_COLUMNS - 1);

  logic [7:0] char_mem [CELLS];
  logic [7:0] attr_mem [CELLS];

  tcce_state_e       state_q, state_d;
  logic [CELL_W-1:0] cursor_q, cursor_d;
  logic [COL_W-1:0]  col_q, col_d;
  logic [CELL_W-1:0] sweep_q, sweep_d;
  cmd_beat_t         item_q, item_d;
  logic [7:0]        fill_attr_q, fill_attr_d;
  logic              rd_ok_q, rd_ok_d;
  logic [7:0]        res_char_q, res_char_d;
  logic [7:0]        res_attr_q, res_attr_d;
  logic              out_valid_q, out_valid_d;
  rsp_beat_t         out_q, out_d;

  logic [CELL_W-1:0] rd_addr, wr_addr;
  logic              char_we, attr_we;
  logic [7:0]        wr_char, wr_attr;
  logic [7:0]        rd_char_q, rd_attr_q;

  logic              div_start, div_done;
  logic [COL_W-1:0]  div_rem;

  logic              fin, out_free, out_load;
  logic [7:0]        fin_char, fin_attr;
  logic [15:0]       addr_ext;
  logic signed [17:0] target;
  logic [CELL_W-1:0] clamped;
  logic [COL_W-1:0]  col_dec;

  tcce_col_div #(
    .DIVIDEND_W  (CELL_W),
    .NUM_COLUMNS (NUM_COLUMNS)
  ) u_col_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (clamped),
    .done_o     (div_done),
    .rem_o      (div_rem)
  );

  always_ff @(posedge clk_i) begin
    if (char_we) begin
      char_mem[wr_addr] <= wr_char;
    end
    if (attr_we) begin
      attr_mem[wr_addr] <= wr_attr;
    end
    rd_char_q <= char_mem[rd_addr];
    rd_attr_q <= attr_mem[rd_addr];
  end

  assign out_free = !out_valid_q || rsp_o.ready;
  assign addr_ext = {5'b0, cmd_i.data.cell_address};
  assign col_dec  = (col_q == '0) ? LAST_COL_C : col_q - COL_W'(1);

  always_comb begin
    if (item_q.opcode == OP_SET) begin
      target = 18'(item_q.cursor_value);
    end else begin
      target = $signed(18'(cursor_q)) + 18'(item_q.cursor_value);
    end
    if (target[17]) begin
      clamped = '0;
    end else if (target > $signed(18'(LAST_CELL))) begin
      clamped = LAST_CELL_C;
    end else begin
      clamped = target[CELL_W-1:0];
    end
  end

  always_comb begin
    state_d     = state_q;
    cursor_d    = cursor_q;
    col_d       = col_q;
    sweep_d     = sweep_q;
    item_d      = item_q;
    fill_attr_d = fill_attr_q;
    rd_ok_d     = rd_ok_q;
    res_char_d  = res_char_q;
    res_attr_d  = res_attr_q;
    out_d       = out_q;
    out_load    = 1'b0;
    rd_addr     = cursor_q - CELL_W'(1);
    wr_addr     = cursor_q;
    wr_char     = CH_SPACE;
    wr_attr     = fill_attr_q;
    char_we     = 1'b0;
    attr_we     = 1'b0;
    div_start   = 1'b0;
    fin         = 1'b0;
    fin_char    = 8'd0;
    fin_attr    = 8'd0;
    cmd_i.ready = 1'b0;

    case (state_q)
      ST_INIT, ST_CLEAR: begin
        wr_addr = sweep_q;
        wr_attr = (state_q == ST_INIT) ? 8'd0 : fill_attr_q;
        char_we = 1'b1;
        attr_we = 1'b1;
        sweep_d = sweep_q + CELL_W'(1);
        if (sweep_q == LAST_CELL_C) begin
          sweep_d = '0;
          if (state_q == ST_INIT) begin
            state_d = ST_IDLE;
          end else begin
            fin = 1'b1;
          end
        end
      end
      ST_IDLE: begin
        cmd_i.ready = 1'b1;
        rd_addr     = (addr_ext < 16'(CELLS)) ? addr_ext[CELL_W-1:0] : '0;
        if (cmd_i.valid) begin
          item_d  = cmd_i.data;
          rd_ok_d = addr_ext < 16'(CELLS);
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        case (item_q.opcode)
          OP_PUT: begin
            if (cursor_q == LAST_CELL_C) begin
              fin = 1'b1;
            end else if (item_q.char_code == CH_NEWLINE) begin
              if (cursor_q < LAST_ROW_C) begin
                cursor_d = cursor_q - CELL_W'(col_q) + COLS_C;
                col_d    = '0;
              end
              fin = 1'b1;
            end else if (item_q.char_code == CH_BACKSPACE) begin
              char_we = 1'b1;
              if (cursor_q == '0) begin
                fin = 1'b1;
              end else begin
                wr_addr  = cursor_q - CELL_W'(1);
                cursor_d = cursor_q - CELL_W'(1);
                col_d    = col_dec;
                if (col_q == '0 && cursor_q >= COLS_C) begin
                  state_d = ST_WALK_RD;
                end else begin
                  fin = 1'b1;
                end
              end
            end else begin
              char_we  = 1'b1;
              wr_char  = item_q.char_code;
              cursor_d = cursor_q + CELL_W'(1);
              col_d    = (col_q == LAST_COL_C) ? '0 : col_q + COL_W'(1);
              fin      = 1'b1;
            end
          end
          OP_SET, OP_MOVE: begin
            cursor_d  = clamped;
            div_start = 1'b1;
            state_d   = ST_DIV;
          end
          OP_CLEAR: begin
            fill_attr_d = {item_q.blink_on, item_q.background, item_q.foreground};
            sweep_d     = '0;
            state_d     = ST_CLEAR;
          end
          OP_READ: begin
            fin      = 1'b1;
            fin_char = rd_ok_q ? rd_char_q : 8'd0;
            fin_attr = rd_ok_q ? rd_attr_q : 8'd0;
          end
          default: begin
            fin = 1'b1;
          end
        endcase
      end
      ST_WALK_RD: begin
        if (cursor_q == '0) begin
          fin = 1'b1;
        end else begin
          state_d = ST_WALK_CHK;
        end
      end
      ST_WALK_CHK: begin
        if (rd_char_q == CH_SPACE) begin
          cursor_d = cursor_q - CELL_W'(1);
          col_d    = col_dec;
          state_d  = ST_WALK_RD;
        end else begin
          fin = 1'b1;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          col_d = div_rem;
          fin   = 1'b1;
        end
      end
      ST_EMIT: begin
        fin      = 1'b1;
        fin_char = res_char_q;
        fin_attr = res_attr_q;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    if (fin) begin
      if (out_free) begin
        out_load         = 1'b1;
        out_d.cursor_now = CURSOR_W'(cursor_d);
        out_d.cell_char  = fin_char;
        out_d.cell_attr  = fin_attr;
        state_d          = ST_IDLE;
      end else begin
        res_char_d = fin_char;
        res_attr_d = fin_attr;
        state_d    = ST_EMIT;
      end
    end

    out_valid_d = out_valid_q;
    if (out_valid_q && rsp_o.ready) begin
      out_valid_d = 1'b0;
    end
    if (out_load) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_INIT;
      cursor_q    <= '0;
      col_q       <= '0;
      sweep_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cursor_q    <= cursor_d;
      col_q       <= col_d;
      sweep_q     <= sweep_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q      <= item_d;
    fill_attr_q <= fill_attr_d;
    rd_ok_q     <= rd_ok_d;
    res_char_q  <= res_char_d;
    res_attr_q  <= res_attr_d;
    out_q       <= out_d;
  end

  assign rsp_o.valid = out_valid_q;
  assign rsp_o.data  = out_q;

endmodule

`default_nettype wire

// File: test/tcce_checker.sv
`timescale 1ns / 1ps

module tcce_checker import tcce_pkg::*; #(
  parameter int NUM_COLUMNS = 80,
  parameter int NUM_ROWS    = 25
) (
  input  logic clk_i,
  input  logic rst_ni,
  tcce_cmd_if  cmd,
  tcce_rsp_if  rsp,
  output int   fail_o,
  output int   pending_o,
  output int   checked_o
);

  localparam int SCREEN_CELLS = NUM_COLUMNS * NUM_ROWS;
  localparam int LAST_CELL    = SCREEN_CELLS - 1;

  logic [7:0] glyph_mem [SCREEN_CELLS];
  logic [7:0] attr_mem  [SCREEN_CELLS];
  int         cursor_pos;
  rsp_beat_t  cell_reports_q [$];

  function automatic int clamp_to_screen(input int v);
    if (v < 0) return 0;
    if (v > LAST_CELL) return LAST_CELL;
    return v;
  endfunction

  function automatic void type_char(input logic [7:0] ch);
    int pos;
    int row;
    int col;
    pos = cursor_pos;
    row = pos / NUM_COLUMNS;
    col = pos % NUM_COLUMNS;
    if (pos >= LAST_CELL) return;
    if (ch == CH_NEWLINE) begin
      if (row != NUM_ROWS - 1) cursor_pos = (row + 1) * NUM_COLUMNS;
    end else if (ch == CH_BACKSPACE) begin
      if (pos == 0) begin
        glyph_mem[0] = CH_SPACE;
      end else begin
        pos--;
        glyph_mem[pos] = CH_SPACE;
        // leaving column 0 walks back over blank cells
        if (col == 0 && row != 0) begin
          while (pos != 0 && glyph_mem[pos - 1] == CH_SPACE) pos--;
        end
        cursor_pos = pos;
      end
    end else begin
      glyph_mem[pos] = ch;
      cursor_pos = pos + 1;
    end
  endfunction

  function automatic rsp_beat_t run_console_cmd(input cmd_beat_t c);
    rsp_beat_t  r;
    logic [7:0] attr;
    int         k;
    r = '0;
    case (c.opcode)
      OP_PUT:  type_char(c.char_code);
      OP_SET:  cursor_pos = clamp_to_screen(int'($signed(c.cursor_value)));
      OP_MOVE: cursor_pos = clamp_to_screen(cursor_pos + int'($signed(c.cursor_value)));
      OP_CLEAR: begin
        attr = {c.blink_on, c.background, c.foreground};
        for (k = 0; k < SCREEN_CELLS; k++) begin
          glyph_mem[k] = CH_SPACE;
          attr_mem[k]  = attr;
        end
      end
      OP_READ: begin
        if (c.cell_address < SCREEN_CELLS) begin
          r.cell_char = glyph_mem[c.cell_address];
          r.cell_attr = attr_mem[c.cell_address];
        end
      end
      default: ;
    endcase
    r.cursor_now = cursor_pos[CURSOR_W-1:0];
    return r;
  endfunction

  function automatic void check_field(input string name, input int want, input int got);
    if (want != got) begin
      $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
      fail_o++;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    rsp_beat_t want;
    int        k;
    if (!rst_ni) begin
      for (k = 0; k < SCREEN_CELLS; k++) begin
        glyph_mem[k] = CH_SPACE;
        attr_mem[k]  = '0;
      end
      cursor_pos = 0;
      cell_reports_q.delete();
      fail_o    = 0;
      pending_o = 0;
      checked_o = 0;
    end else begin
      if (rsp.valid && rsp.ready) begin
        if (cell_reports_q.size() == 0) begin
          $display("%0t: unexpected response beat, expected none actual cursor %0d char %0d attr %0d",
                   $time, rsp.data.cursor_now, rsp.data.cell_char, rsp.data.cell_attr);
          fail_o++;
        end else begin
          want = cell_reports_q.pop_front();
          check_field("cursor_now", want.cursor_now, rsp.data.cursor_now);
          check_field("cell_char", want.cell_char, rsp.data.cell_char);
          check_field("cell_attr", want.cell_attr, rsp.data.cell_attr);
          checked_o++;
        end
      end
      if (cmd.valid && cmd.ready) cell_reports_q.push_back(run_console_cmd(cmd.data));
      pending_o = cell_reports_q.size();
    end
  end

endmodule

// File: test/tb.sv
`timescale 1ns / 1ps

module tb;
  import tcce_pkg::*;

  localparam int COLS         = 80;
  localparam int ROWS         = 25;
  localparam int SCREEN_CELLS = COLS * ROWS;
  localparam int LAST_CELL    = SCREEN_CELLS - 1;
  localparam int RANDOM_ITEMS = 625;
  localparam int QUIET_TAIL   = 100;
  localparam int LONG_HOLD    = 400;
  localparam int DRAIN_CYCLES = 50;

  localparam logic [2:0] OP_SPARE_FIRST = 3'd5;
  localparam logic [2:0] OP_SPARE_LAST  = 3'd7;

  logic clk_i = 1'b0;
  logic rst_ni;
  bit   idle_on;
  bit   long_hold_req;
  int   fail_count;
  int   pending;
  int   checked;

  int n_typed, n_newline, n_backspace, n_set, n_move, n_clear, n_read, n_spare;

  tcce_cmd_if cmd_if ();
  tcce_rsp_if rsp_if ();

  text_console_cursor_engine_core #(
    .NUM_COLUMNS(COLS),
    .NUM_ROWS   (ROWS)
  ) u_top (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .cmd_i (cmd_if),
    .rsp_o (rsp_if)
  );

  tcce_checker #(
    .NUM_COLUMNS(COLS),
    .NUM_ROWS   (ROWS)
  ) u_checker (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cmd      (cmd_if),
    .rsp      (rsp_if),
    .fail_o   (fail_count),
    .pending_o(pending),
    .checked_o(checked)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  initial begin
    #100_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin : rsp_ready_gen
    int unsigned stall;
    rsp_if.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        rsp_if.ready <= 1'b0;
        repeat (LONG_HOLD - 1) @(posedge clk_i);
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
        stall = $urandom_range(1, 13);
        rsp_if.ready <= 1'b0;
        repeat (stall - 1) @(posedge clk_i);
      end else begin
        rsp_if.ready <= 1'b1;
      end
    end
  end

  function automatic cmd_beat_t make_cmd(input logic [2:0] op, input logic [7:0] ch,
                                         input logic [15:0] val, input logic [10:0] addr,
                                         input logic [7:0] attr);
    cmd_beat_t b;
    b.opcode       = op;
    b.char_code    = ch;
    b.cursor_value = val;
    {b.blink_on, b.background, b.foreground} = attr;
    b.cell_address = addr;
    return b;
  endfunction

  function automatic cmd_beat_t random_cmd();
    cmd_beat_t   b;
    int unsigned pick;
    int unsigned sel;
    b = make_cmd(OP_PUT, 8'($urandom_range(0, 255)), 16'($urandom_range(0, 65535)),
                 11'($urandom_range(0, 2047)), 8'($urandom_range(0, 255)));
    pick = $urandom_range(0, 99);
    sel  = $urandom_range(0, 99);
    if (pick < 45) begin
      if (sel < 10) b.char_code = CH_NEWLINE;
      else if (sel < 20) b.char_code = CH_BACKSPACE;
      else if (sel < 30) b.char_code = CH_SPACE;
      else if (sel < 85) b.char_code = 8'($urandom_range(33, 126));
    end else if (pick < 55) begin
      b.opcode = OP_SET;
      if (sel < 60) b.cursor_value = 16'($urandom_range(0, LAST_CELL));
      else if (sel < 80) b.cursor_value = 16'($urandom_range(LAST_CELL - 100, LAST_CELL));
    end else if (pick < 65) begin
      b.opcode = OP_MOVE;
      if (sel < 50) b.cursor_value = 16'(int'($urandom_range(0, 400)) - 200);
      else if (sel < 70) b.cursor_value = (sel % 2) ? 16'(COLS) : 16'(-COLS);
    end else if (pick < 68) begin
      b.opcode = OP_CLEAR;
    end else if (pick < 95) begin
      b.opcode = OP_READ;
      if (sel < 75) b.cell_address = 11'($urandom_range(0, LAST_CELL));
    end else begin
      b.opcode = 3'($urandom_range(OP_SPARE_FIRST, OP_SPARE_LAST));
    end
    return b;
  endfunction

  task automatic issue(input cmd_beat_t b);
    if (idle_on && $urandom_range(0, 7) == 0) begin
      cmd_if.valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk_i);
    end
    case (b.opcode)
      OP_PUT: begin
        if (b.char_code == CH_NEWLINE) n_newline++;
        else if (b.char_code == CH_BACKSPACE) n_backspace++;
        else n_typed++;
      end
      OP_SET:   n_set++;
      OP_MOVE:  n_move++;
      OP_CLEAR: n_clear++;
      OP_READ:  n_read++;
      default:  n_spare++;
    endcase
    cmd_if.valid <= 1'b1;
    cmd_if.data  <= b;
    do @(posedge clk_i); while (!cmd_if.ready);
  endtask

  task automatic wait_all_answered();
    cmd_if.valid <= 1'b0;
    @(posedge clk_i);
    wait (pending == 0);
    @(posedge clk_i);
  endtask

  initial begin : stimulus
    cmd_if.valid  = 1'b0;
    cmd_if.data   = '0;
    rst_ni        = 1'b0;
    idle_on       = 1'b1;
    long_hold_req = 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    issue(make_cmd(OP_READ, 8'h00, 16'h0000, 11'd0, 8'h00));
    issue(make_cmd(OP_READ, 8'hFF, 16'hFFFF, 11'(LAST_CELL), 8'hFF));
    issue(make_cmd(OP_READ, 8'h00, 16'h0000, 11'(SCREEN_CELLS), 8'h00));
    issue(make_cmd(OP_READ, 8'h00, 16'h0000, 11'h7FF, 8'h00));
    issue(make_cmd(OP_PUT, CH_BACKSPACE, 16'h0000, 11'd0, 8'h00));
    issue(make_cmd(OP_PUT, 8'h41, 16'h0000, 11'd0, 8'h00));
    issue(make_cmd(OP_PUT, 8'hFF, 16'h0000, 11'd0, 8'h00));
    issue(make_cmd(OP_PUT, 8'h00, 16'h0000, 11'd0, 8'h00));
    issue(make_cmd(OP_PUT, CH_NEWLINE, 16'h0000, 11'd0, 8'h00));
    issue(make_cmd(OP_PUT, CH_BACKSPACE, 16'h0000, 11'd0, 8'h00));
    issue(make_cmd(OP_READ, 8'h00, 16'h0000, 11'd2, 8'h00));
    issue(make_cmd(OP_SET, 8'h00, 16'h8000, 11'd0, 8'h00));
    issue(make_cmd(OP_SET, 8'h00, 16'h7FFF, 11'd0, 8'h00));
    issue(make_cmd(OP_PUT, 8'h5A, 16'h0000, 11'd0, 8'h00));
    issue(make_cmd(OP_PUT, CH_NEWLINE, 16'h0000, 11'd0, 8'h00));
    issue(make_cmd(OP_MOVE, 8'h00, 16'h8000, 11'd0, 8'h00));
    issue(make_cmd(OP_MOVE, 8'h00, 16'h7FFF, 11'd0, 8'h00));
    issue(make_cmd(OP_SET, 8'h00, 16'(LAST_CELL - COLS + 1), 11'd0, 8'h00));
    issue(make_cmd(OP_PUT, CH_NEWLINE, 16'h0000, 11'd0, 8'h00));
    issue(make_cmd(OP_PUT, CH_BACKSPACE, 16'h0000, 11'd0, 8'h00));
    issue(make_cmd(OP_CLEAR, 8'h00, 16'h0000, 11'd0, 8'hFF));
    issue(make_cmd(OP_READ, 8'h00, 16'h0000, 11'd5, 8'h00));
    issue(make_cmd(OP_CLEAR, 8'h00, 16'h0000, 11'd0, 8'h00));
    for (int op = OP_SPARE_FIRST; op <= OP_SPARE_LAST; op++)
      issue(make_cmd(3'(op), 8'h00, 16'h0000, 11'd0, 8'h00));
    wait_all_answered();

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      idle_on = (i < RANDOM_ITEMS - QUIET_TAIL) && ((i / 75) % 2 == 0);
      if (i == 150) long_hold_req = 1'b1;
      if (i == 350) wait_all_answered();
      issue(random_cmd());
    end
    wait_all_answered();
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Sent %0d typed, %0d newline, %0d backspace, %0d set, %0d move, %0d clear,",
             n_typed, n_newline, n_backspace, n_set, n_move, n_clear);
    $display("  %0d read and %0d spare-opcode commands; %0d response beats checked",
             n_read, n_spare, checked);
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
